// ----- design/pfla_pkg.sv -----
// shared types, constants and codes for the page free-list allocator
package pfla_pkg;

  localparam int MAX_PAGES  = 65536;
  localparam int MAP_PERIOD = 1024;
  localparam int MAP_OFFSET = 1008;

  localparam int ID_SPACE   = 65536;
  localparam int PAGE_LIMIT = (MAX_PAGES < ID_SPACE) ? MAX_PAGES : ID_SPACE;
  localparam int ADDR_W     = 16;
  localparam int CNT_W      = 17;
  localparam int PH_W       = $clog2(MAP_PERIOD);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] page_id;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_page;
    logic [1:0]        status;
  } out_t;

  // one word per page: mark, link flag, link
  typedef struct packed {
    logic              in_use;
    logic              link_valid;
    logic [ADDR_W-1:0] next_link;
  } entry_t;

  // bump unit status toward the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] cand;
    logic             full;
  } bump_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_EXEC
  } seq_state_t;

endpackage

// ----- design/pfla_ram.sv -----
// generic single-write, single-read ram with registered read
module pfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/pfla_bump.sv -----
// page counter with map-slot skip and limit compare
module pfla_bump (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  output pfla_pkg::bump_t      bump
);

  logic [pfla_pkg::CNT_W-1:0] page_total_r, page_total_nxt;
  logic [pfla_pkg::PH_W-1:0]  phase_r, phase_nxt;
  logic                       skip;
  logic [pfla_pkg::PH_W-1:0]  phase_p1, phase_p2;

  function automatic logic [pfla_pkg::PH_W-1:0] ph_inc(input logic [pfla_pkg::PH_W-1:0] p);
    logic [pfla_pkg::PH_W-1:0] r;
    if (p == pfla_pkg::PH_W'(pfla_pkg::MAP_PERIOD - 1)) begin
      r = '0;
    end else begin
      r = p + pfla_pkg::PH_W'(1);
    end
    return r;
  endfunction

  // phase tracks page_total mod period
  assign skip     = ({{(pfla_pkg::CNT_W-pfla_pkg::PH_W){1'b0}}, phase_r}
                     == pfla_pkg::CNT_W'(pfla_pkg::MAP_OFFSET));
  assign phase_p1 = ph_inc(phase_r);
  assign phase_p2 = ph_inc(phase_p1);

  assign bump.cand = page_total_r + pfla_pkg::CNT_W'(skip);
  assign bump.full = (bump.cand >= pfla_pkg::CNT_W'(pfla_pkg::PAGE_LIMIT));

  always_comb begin
    page_total_nxt = page_total_r;
    phase_nxt      = phase_r;
    if (advance) begin
      page_total_nxt = bump.cand + pfla_pkg::CNT_W'(1);
      phase_nxt      = skip ? phase_p2 : phase_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_total_r <= pfla_pkg::CNT_W'(1);
      phase_r      <= pfla_pkg::PH_W'(1);
    end else begin
      page_total_r <= page_total_nxt;
      phase_r      <= phase_nxt;
    end
  end

endmodule

// ----- design/page_free_list_allocator.sv -----
// top level: request sequencer, free-list head and page word memory
// each request reads its page word from memory, then the sequencer decides and writes back
// the next request is taken only after the previous one leaves the execute state
// reset: synchronous active-low rst_n; afterwards a clearing pass writes all 65536 page
//   words, one a cycle, and no request is taken until the pass ends
// a finished result waits in the output register while the next request is taken
module page_free_list_allocator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pfla_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pfla_pkg::out_t  out_data
);

  pfla_pkg::seq_state_t          state_r, state_nxt;
  logic [pfla_pkg::ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [pfla_pkg::ADDR_W-1:0]   free_head_r, free_head_nxt;
  logic                          free_head_valid_r, free_head_valid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  pfla_pkg::out_t                out_r, out_nxt;
  pfla_pkg::in_t                 req_r, req_nxt;

  // page word memory ports
  logic                          ram_we;
  logic [pfla_pkg::ADDR_W-1:0]   ram_waddr;
  pfla_pkg::entry_t              ram_wdata;
  logic                          ram_re;
  logic [pfla_pkg::ADDR_W-1:0]   ram_raddr;
  pfla_pkg::entry_t              ram_rdata;

  logic                          bump_adv;
  pfla_pkg::bump_t               bump;
  logic                          commit;

  pfla_ram #(
    .WIDTH ($bits(pfla_pkg::entry_t)),
    .DEPTH (pfla_pkg::ID_SPACE)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfla_bump u_bump (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (bump_adv),
    .bump    (bump)
  );

  // result can be loaded when the output slot is empty or drains this cycle
  assign commit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt           = state_r;
    clr_addr_nxt        = clr_addr_r;
    free_head_nxt       = free_head_r;
    free_head_valid_nxt = free_head_valid_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_nxt             = out_r;
    req_nxt             = req_r;
    ram_we              = 1'b0;
    ram_waddr           = clr_addr_r;
    ram_wdata           = '0;
    ram_re              = 1'b0;
    // free reads the named page, allocate reads the list head
    ram_raddr           = (in_data.kind == pfla_pkg::KIND_FREE) ? in_data.page_id
                                                                 : free_head_r;
    bump_adv            = 1'b0;
    in_ready            = 1'b0;

    unique case (state_r)
      pfla_pkg::SEQ_CLEAR: begin
        // zero every page word: no page in use
        ram_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + pfla_pkg::ADDR_W'(1);
        if (&clr_addr_r) begin
          state_nxt = pfla_pkg::SEQ_IDLE;
        end
      end
      pfla_pkg::SEQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ram_re    = 1'b1;
          req_nxt   = in_data;
          state_nxt = pfla_pkg::SEQ_EXEC;
        end
      end
      pfla_pkg::SEQ_EXEC: begin
        if (commit) begin
          state_nxt            = pfla_pkg::SEQ_IDLE;
          out_valid_nxt        = 1'b1;
          out_nxt.granted_page = '0;
          out_nxt.status       = pfla_pkg::ST_OK;
          if (req_r.kind == pfla_pkg::KIND_FREE) begin
            if (!ram_rdata.in_use) begin
              // page not in use, including page 0 and never-granted pages
              out_nxt.status = pfla_pkg::ST_FORMAT;
            end else begin
              // push onto the list, clearing its mark
              ram_we               = 1'b1;
              ram_waddr            = req_r.page_id;
              ram_wdata.in_use     = 1'b0;
              ram_wdata.link_valid = free_head_valid_r;
              ram_wdata.next_link  = free_head_r;
              free_head_nxt        = req_r.page_id;
              free_head_valid_nxt  = 1'b1;
            end
          end else if (free_head_valid_r) begin
            if (ram_rdata.in_use) begin
              // head page already marked: format error, state kept
              out_nxt.status = pfla_pkg::ST_FORMAT;
            end else begin
              // pop the head, keep its link word, set the mark
              ram_we               = 1'b1;
              ram_waddr            = free_head_r;
              ram_wdata            = ram_rdata;
              ram_wdata.in_use     = 1'b1;
              free_head_nxt        = ram_rdata.next_link;
              free_head_valid_nxt  = ram_rdata.link_valid;
              out_nxt.granted_page = free_head_r;
            end
          end else if (bump.full) begin
            // counter saturates
            out_nxt.status = pfla_pkg::ST_FULL;
          end else begin
            // fresh page from the counter
            bump_adv             = 1'b1;
            ram_we               = 1'b1;
            ram_waddr            = bump.cand[pfla_pkg::ADDR_W-1:0];
            ram_wdata.in_use     = 1'b1;
            out_nxt.granted_page = bump.cand[pfla_pkg::ADDR_W-1:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfla_pkg::SEQ_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r        <= '0;
      free_head_r       <= '0;
      free_head_valid_r <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      clr_addr_r        <= clr_addr_nxt;
      free_head_r       <= free_head_nxt;
      free_head_valid_r <= free_head_valid_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfla_pkg::SEQ_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == pfla_pkg::SEQ_EXEC))
    else $error("accepted beat not followed by execute");

  a_error_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != pfla_pkg::ST_OK)) |-> (out_data.granted_page == '0))
    else $error("error result carries a page id");

  a_head_rise_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(free_head_valid_r) |->
      $past(state_r == pfla_pkg::SEQ_EXEC && req_r.kind == pfla_pkg::KIND_FREE))
    else $error("free list became non-empty without a free");

  a_bump_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    bump_adv |-> (!bump.full && !free_head_valid_r))
    else $error("counter advanced while full or list non-empty");
`endif

endmodule
